// ----- hw/rtl/stte_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stte_pkg
// shared types and constants for the session table with timeout eviction
// ----------------------------------------------------------------------------
package stte_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int LIVE_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [19:0] NS_PER_MS = 20'd1000000;
  localparam logic [15:0] PIN_MAX   = 16'hFFFF;

  // operations
  localparam logic [1:0] OP_CREATE   = 2'd0;
  localparam logic [1:0] OP_GET      = 2'd1;
  localparam logic [1:0] OP_RELEASE  = 2'd2;
  localparam logic [1:0] OP_SHUTDOWN = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_CAPACITY  = 3'd2;
  localparam logic [2:0] ST_CLASH     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_DESTROYED = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIVE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] now_ns;
    logic [31:0] new_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] handle_out;
    logic        evicted;
    logic [31:0] evicted_handle;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic match;
    logic evict_pick;
  } slot_eval_t;

endpackage
`default_nettype wire

// ----- hw/rtl/stte_slot_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stte_slot_eval
// shared per-cycle compare unit: key match and eviction choice for one slot
// ----------------------------------------------------------------------------
module stte_slot_eval (
  input  wire logic                entry_valid,
  input  wire logic [127:0]        entry_key,
  input  wire logic [15:0]         entry_pin,
  input  wire logic [63:0]         entry_time,
  input  wire logic [127:0]        req_key,
  input  wire logic [63:0]         now_ns,
  input  wire logic [63:0]         timeout_ns,
  input  wire logic                best_found,
  input  wire logic [63:0]         best_time,
  output stte_pkg::slot_eval_t     result
);
  import stte_pkg::*;

  logic [63:0] idle_ns;
  logic        idle_enough;
  logic        older;

  assign idle_ns     = now_ns - entry_time;
  assign idle_enough = (timeout_ns != 64'd0) && (idle_ns >= timeout_ns);
  // strict compare keeps the lowest slot on equal times
  assign older       = !best_found || (entry_time < best_time);

  assign result.match      = entry_valid && (entry_key == req_key);
  assign result.evict_pick = entry_valid && (entry_pin == 16'd0) && idle_enough && older;

endmodule
`default_nettype wire

// ----- hw/rtl/session_table_timeout_eviction.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// session_table_timeout_eviction
// session table with pin counts and idle-timeout eviction on create
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_stall/in_item) carries one request item: create,
//   get, release or shutdown. in_stall is high while a request is in work.
//   out channel (out_valid/out_stall/out_item) returns result items; an item
//   is held in the output register until the receiver drops out_stall.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes max_live
//   (index 0) and idle_timeout_ms (index 1); cfg_ready is always high.
// sequencing:
//   create/get/release: an accept step, a scan over all SLOTS entries,
//   one slot at a time through the shared compare unit, then a finish
//   step that loads the result item once the output is free.
//   shutdown: an accept step, then a walk over the slots up to the last
//   live one, each live slot emitting one result item; an empty table
//   gives a single item from the finish step.
//   a stalled output holds the finish step and the shutdown at a live slot.
// reset:
//   synchronous rst clears valid bits, live count, config registers, out_valid
//   and the sequencer; entry payload is only read while its valid bit is set.
// ----------------------------------------------------------------------------
module session_table_timeout_eviction (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire stte_pkg::in_item_t             in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output stte_pkg::out_item_t                 out_item,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [stte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import stte_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_SHUT} state_t;

  state_t state;

  // configuration
  logic [LIVE_W-1:0] max_live;
  logic [31:0]       idle_timeout_ms;

  // table
  logic [SLOTS-1:0]  valid;
  logic [127:0]      key_mem    [SLOTS];
  logic [31:0]       handle_mem [SLOTS];
  logic [15:0]       pin_mem    [SLOTS];
  logic [63:0]       time_mem   [SLOTS];
  logic [LIVE_W-1:0] live_count;

  // latched request
  logic [1:0]   req_op;
  logic [127:0] req_key;
  logic [63:0]  req_now;
  logic [31:0]  req_handle;
  logic [63:0]  timeout_ns;
  logic         need_evict;

  // scan results
  logic [IDX_W-1:0] idx;
  logic             match_found;
  logic [IDX_W-1:0] match_idx;
  logic [31:0]      match_handle;
  logic [15:0]      match_pin;
  logic             vic_found;
  logic [IDX_W-1:0] vic_idx;
  logic [63:0]      vic_time;
  logic [31:0]      vic_handle;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  slot_eval_t  ev;
  logic        out_free;
  logic        accept;
  logic        clash;
  logic        slot_ok;
  logic [IDX_W-1:0] ins_idx;
  logic [SLOTS-1:0] rest_valid;

  // finish-step outcome
  out_item_t         fin_item;
  logic [SLOTS-1:0]  fin_valid;
  logic [LIVE_W-1:0] fin_live;
  logic              fin_insert;
  out_item_t         shut_item;
  logic              emit;

  stte_slot_eval u_eval (
    .entry_valid (valid[idx]),
    .entry_key   (key_mem[idx]),
    .entry_pin   (pin_mem[idx]),
    .entry_time  (time_mem[idx]),
    .req_key     (req_key),
    .now_ns      (req_now),
    .timeout_ns  (timeout_ns),
    .best_found  (vic_found),
    .best_time   (vic_time),
    .result      (ev)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // a result item is loaded into the output register this cycle
  assign emit = out_free && ((state == S_FIN) || ((state == S_SHUT) && valid[idx]));

  // clash ignores the slot freed by this eviction
  assign clash = match_found && !(need_evict && vic_found && (match_idx == vic_idx));

  // first free slot, with the victim slot counted as free
  always_comb begin
    slot_ok = 1'b1;
    ins_idx = free_idx;
    if (need_evict && (!free_found || (vic_idx < free_idx))) begin
      ins_idx = vic_idx;
    end else if (!free_found) begin
      slot_ok = 1'b0;
    end
  end

  // live slots above the current scan position
  assign rest_valid = (valid >> idx) >> 1;

  // result item, valid bits and live count at the finish step
  always_comb begin
    fin_item      = '0;
    fin_item.last = 1'b1;
    fin_valid     = valid;
    fin_live      = live_count;
    fin_insert    = 1'b0;
    unique case (req_op)
      OP_CREATE: begin
        if (need_evict && !vic_found) begin
          fin_item.status = ST_CAPACITY;
        end else begin
          fin_item.evicted        = need_evict;
          fin_item.evicted_handle = need_evict ? vic_handle : 32'd0;
          // the eviction stands whatever follows
          if (need_evict) begin
            fin_valid[vic_idx] = 1'b0;
            fin_live           = live_count - 1'b1;
          end
          if (clash) begin
            fin_item.status = ST_CLASH;
          end else if (!slot_ok) begin
            fin_item.status = ST_FULL;
          end else begin
            fin_insert          = 1'b1;
            fin_valid[ins_idx]  = 1'b1;
            fin_live            = fin_live + 1'b1;
            fin_item.status     = ST_OK;
            fin_item.slot_index = 4'(ins_idx);
            fin_item.handle_out = req_handle;
          end
        end
      end
      OP_GET, OP_RELEASE: begin
        if (!match_found) begin
          fin_item.status = ST_NOT_FOUND;
        end else begin
          fin_item.status     = ST_OK;
          fin_item.slot_index = 4'(match_idx);
          fin_item.handle_out = match_handle;
        end
      end
      OP_SHUTDOWN: begin
        // reached only when the table was empty
        fin_item.status = ST_EMPTY;
        fin_live        = '0;
      end
      default: ;
    endcase
  end

  // one destroyed entry during shutdown
  always_comb begin
    shut_item            = '0;
    shut_item.status     = ST_DESTROYED;
    shut_item.slot_index = 4'(idx);
    shut_item.handle_out = handle_mem[idx];
    shut_item.last       = (rest_valid == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_live    <= '0;
      idle_timeout_ms <= '0;
      valid       <= '0;
      live_count  <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
      match_found <= 1'b0;
      vic_found   <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_LIVE:     max_live        <= cfg_data[LIVE_W-1:0];
          REG_IDLE_TIMEOUT: idle_timeout_ms <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_op      <= in_item.operation;
            req_key     <= {in_item.key_high, in_item.key_low};
            req_now     <= in_item.now_ns;
            req_handle  <= in_item.new_handle;
            timeout_ns  <= 64'(idle_timeout_ms) * 64'(NS_PER_MS);
            need_evict  <= (max_live != '0) && (live_count >= max_live);
            idx         <= '0;
            match_found <= 1'b0;
            vic_found   <= 1'b0;
            free_found  <= 1'b0;
            if (in_item.operation == OP_SHUTDOWN) begin
              state <= (valid == '0) ? S_FIN : S_SHUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (ev.match) begin
            match_found  <= 1'b1;
            match_idx    <= idx;
            match_handle <= handle_mem[idx];
            match_pin    <= pin_mem[idx];
          end
          if (ev.evict_pick) begin
            vic_found  <= 1'b1;
            vic_idx    <= idx;
            vic_time   <= time_mem[idx];
            vic_handle <= handle_mem[idx];
          end
          if (!valid[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx == IDX_W'(SLOTS - 1)) begin
            state <= S_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_FIN: begin
          if (out_free) begin
            out_item   <= fin_item;
            valid      <= fin_valid;
            live_count <= fin_live;
            state      <= S_IDLE;
            if (fin_insert) begin
              key_mem[ins_idx]    <= req_key;
              handle_mem[ins_idx] <= req_handle;
              pin_mem[ins_idx]    <= 16'd0;
              time_mem[ins_idx]   <= req_now;
            end
            if (match_found && (req_op == OP_GET)) begin
              // pin count saturates
              if (match_pin != PIN_MAX) begin
                pin_mem[match_idx] <= match_pin + 1'b1;
              end
            end
            if (match_found && (req_op == OP_RELEASE)) begin
              if (match_pin != 16'd0) begin
                pin_mem[match_idx] <= match_pin - 1'b1;
              end
              time_mem[match_idx] <= req_now;
            end
          end
        end

        S_SHUT: begin
          if (!valid[idx]) begin
            idx <= idx + 1'b1;
          end else if (out_free) begin
            out_item   <= shut_item;
            valid[idx] <= 1'b0;
            if (rest_valid == '0) begin
              live_count <= '0;
              state      <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
